// ----- hw/rtl/rmth_pkg.sv -----
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median core
// Cell commands, controller states, median source select and defaults.
// ----------------------------------------------------------------------------
package rmth_pkg;

	// Defaults for the top level parameters
	localparam int unsigned MAX_ITEMS_DEF   = 1024;
	localparam int unsigned SAMPLE_BITS_DEF = 32;

	// Fixed port widths
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 11;

	// Command broadcast to every cell of one chain
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_POP,
		CMD_CLEAR
	} cell_cmd_t;

	// Commands for both chains, controller to chains
	typedef struct packed {
		cell_cmd_t lower_cmd;
		cell_cmd_t upper_cmd;
	} chain_ctl_t;

	// Controller sequence
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MOVE,
		ST_INSERT,
		ST_MEDIAN,
		ST_DONE
	} state_t;

	// Where the new median comes from
	typedef enum logic [1:0] {
		MED_LOWER,
		MED_UPPER,
		MED_MEAN
	} med_sel_t;

endpackage

// ----- hw/rtl/rmth_cell.sv -----
// ----------------------------------------------------------------------------
// rmth_cell: one slot of a sorted chain
// Holds one sample and a valid bit. On push it keeps its value, takes the
// new word or takes its upper neighbor's value; on pop it takes its lower
// neighbor's value. The chain stays sorted with the best value in slot 0.
// ----------------------------------------------------------------------------
module rmth_cell #(
	parameter int unsigned W      = rmth_pkg::SAMPLE_BITS_DEF,
	parameter bit          IS_MAX = 1'b1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmth_pkg::cell_cmd_t cmd,
	input  logic signed [W-1:0] ins_val,
	input  logic signed [W-1:0] prev_val,
	input  logic                prev_valid,
	input  logic                prev_keep,
	input  logic signed [W-1:0] next_val,
	input  logic                next_valid,
	output logic signed [W-1:0] val,
	output logic                valid,
	output logic                keep
);

	logic signed [W-1:0] val_q;
	logic                valid_q;

	// Keep the slot on push if it holds a value that ranks at or above the new word
	always_comb begin
		if (IS_MAX) begin
			keep = valid_q && (val_q >= ins_val);
		end else begin
			keep = valid_q && (val_q <= ins_val);
		end
	end

	// Hold, insert, shift down, shift up or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd)
				rmth_pkg::CMD_HOLD: begin
					valid_q <= valid_q;
				end
				rmth_pkg::CMD_PUSH: begin
					if (!keep) begin
						valid_q <= prev_keep ? 1'b1 : prev_valid;
					end
				end
				rmth_pkg::CMD_POP: begin
					valid_q <= next_valid;
				end
				rmth_pkg::CMD_CLEAR: begin
					valid_q <= 1'b0;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// Payload follows the same moves, no reset
	always_ff @(posedge clk) begin
		if (cmd == rmth_pkg::CMD_PUSH && !keep) begin
			val_q <= prev_keep ? ins_val : prev_val;
		end else if (cmd == rmth_pkg::CMD_POP) begin
			val_q <= next_val;
		end
	end

	assign val   = val_q;
	assign valid = valid_q;

endmodule

// ----- hw/rtl/rmth_chain.sv -----
// ----------------------------------------------------------------------------
// rmth_chain: row of sorted cells acting as a priority queue
// Slot 0 always holds the top (largest for the lower half, smallest for
// the upper half). Push and pop each act on all cells at once.
// ----------------------------------------------------------------------------
module rmth_chain #(
	parameter int unsigned W      = rmth_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned DEPTH  = rmth_pkg::MAX_ITEMS_DEF / 2 + 1,
	parameter bit          IS_MAX = 1'b1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmth_pkg::cell_cmd_t cmd,
	input  logic signed [W-1:0] ins_val,
	output logic signed [W-1:0] top_val,
	output logic                top_valid
);

	logic signed [W-1:0] val   [DEPTH];
	logic                valid [DEPTH];
	logic                keep  [DEPTH];

	// Build the row, slot 0 at the top
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [W-1:0] prev_val;
		logic                prev_valid;
		logic                prev_keep;
		logic signed [W-1:0] next_val;
		logic                next_valid;

		if (i == 0) begin : g_head
			assign prev_val   = ins_val;
			assign prev_valid = 1'b0;
			assign prev_keep  = 1'b1;
		end else begin : g_body
			assign prev_val   = val[i-1];
			assign prev_valid = valid[i-1];
			assign prev_keep  = keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_val   = val[i];
			assign next_valid = 1'b0;
		end else begin : g_link
			assign next_val   = val[i+1];
			assign next_valid = valid[i+1];
		end

		rmth_cell #(
			.W      (W),
			.IS_MAX (IS_MAX)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.ins_val    (ins_val),
			.prev_val   (prev_val),
			.prev_valid (prev_valid),
			.prev_keep  (prev_keep),
			.next_val   (next_val),
			.next_valid (next_valid),
			.val        (val[i]),
			.valid      (valid[i]),
			.keep       (keep[i])
		);
	end

	assign top_val   = val[0];
	assign top_valid = valid[0];

endmodule

// ----- hw/rtl/rmth_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmth_ctrl: sequencer, occupancy counts, median and result register
// Decides where each sample goes, issues the chain commands one step per
// cycle, forms the new median and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module rmth_ctrl #(
	parameter int unsigned MAX_ITEMS   = rmth_pkg::MAX_ITEMS_DEF,
	parameter int unsigned SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned DEPTH       = MAX_ITEMS / 2 + 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [rmth_pkg::WORD_W-1:0]     sample,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rmth_pkg::WORD_W-1:0]     median_out,
	output logic        [rmth_pkg::COUNT_W-1:0]    count_held,
	output logic                                   overflow_flag,
	input  logic signed [SAMPLE_BITS-1:0]          lower_top,
	input  logic                                   lower_top_valid,
	input  logic signed [SAMPLE_BITS-1:0]          upper_top,
	input  logic                                   upper_top_valid,
	output rmth_pkg::chain_ctl_t                   chain_ctl,
	output logic signed [SAMPLE_BITS-1:0]          lower_ins,
	output logic signed [SAMPLE_BITS-1:0]          upper_ins
);

	localparam int unsigned SIZE_W = $clog2(DEPTH + 1);
	localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int unsigned S      = SAMPLE_BITS;

	rmth_pkg::state_t   state_q, state_d;
	rmth_pkg::med_sel_t med_sel_q, med_sel_d;
	logic               to_upper_q, to_upper_d;
	logic               move_q, move_d;
	logic               flag_q;
	logic signed [S-1:0] sample_q;
	logic signed [S-1:0] median_q;
	logic [SIZE_W-1:0]  lower_size_q, upper_size_q;
	logic [CNT_W-1:0]   total;
	logic [31:0]        total_wide;
	logic               full;
	logic               gt_median;
	logic               accept;
	logic               out_free;
	logic               load_out;
	logic signed [S:0]  sum_w, adj_w;
	logic signed [S-1:0] mean_w;

	logic                                  out_valid_q;
	logic signed [rmth_pkg::WORD_W-1:0]    median_out_q;
	logic        [rmth_pkg::COUNT_W-1:0]   count_q;
	logic                                  flag_out_q;

	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign total      = CNT_W'(lower_size_q) + CNT_W'(upper_size_q);
	assign total_wide = 32'(total);
	assign full       = total >= CNT_W'(MAX_ITEMS);
	assign gt_median  = sample_q > median_q;

	// Mean of both tops at one extra bit, rounded toward zero
	always_comb begin
		sum_w  = {lower_top[S-1], lower_top} + {upper_top[S-1], upper_top};
		adj_w  = sum_w + (S+1)'(sum_w[S]);
		mean_w = adj_w[S:1];
	end

	// Plan the moves for the sample in hand
	always_comb begin
		to_upper_d = gt_median;
		move_d     = 1'b0;
		med_sel_d  = rmth_pkg::MED_MEAN;
		if (lower_size_q == upper_size_q) begin
			med_sel_d = gt_median ? rmth_pkg::MED_UPPER : rmth_pkg::MED_LOWER;
		end else if (lower_size_q > upper_size_q) begin
			move_d = !gt_median;
		end else begin
			move_d = gt_median;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rmth_pkg::ST_IDLE: begin
				if (in_valid) state_d = rmth_pkg::ST_DECIDE;
			end
			rmth_pkg::ST_DECIDE: begin
				if (full) begin
					state_d = rmth_pkg::ST_DONE;
				end else if (move_d) begin
					state_d = rmth_pkg::ST_MOVE;
				end else begin
					state_d = rmth_pkg::ST_INSERT;
				end
			end
			rmth_pkg::ST_MOVE:   state_d = rmth_pkg::ST_INSERT;
			rmth_pkg::ST_INSERT: state_d = rmth_pkg::ST_MEDIAN;
			rmth_pkg::ST_MEDIAN: state_d = rmth_pkg::ST_DONE;
			rmth_pkg::ST_DONE: begin
				if (out_free) state_d = rmth_pkg::ST_IDLE;
			end
			default: state_d = rmth_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequence: chain commands, insert words, handshakes
	always_comb begin
		chain_ctl.lower_cmd = rmth_pkg::CMD_HOLD;
		chain_ctl.upper_cmd = rmth_pkg::CMD_HOLD;
		in_stall            = 1'b1;
		load_out            = 1'b0;
		lower_ins           = sample_q;
		upper_ins           = sample_q;
		unique case (state_q)
			rmth_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && restart) begin
					chain_ctl.lower_cmd = rmth_pkg::CMD_CLEAR;
					chain_ctl.upper_cmd = rmth_pkg::CMD_CLEAR;
				end
			end
			rmth_pkg::ST_MOVE: begin
				lower_ins = upper_top;
				upper_ins = lower_top;
				if (to_upper_q) begin
					chain_ctl.upper_cmd = rmth_pkg::CMD_POP;
					chain_ctl.lower_cmd = rmth_pkg::CMD_PUSH;
				end else begin
					chain_ctl.lower_cmd = rmth_pkg::CMD_POP;
					chain_ctl.upper_cmd = rmth_pkg::CMD_PUSH;
				end
			end
			rmth_pkg::ST_INSERT: begin
				if (to_upper_q) begin
					chain_ctl.upper_cmd = rmth_pkg::CMD_PUSH;
				end else begin
					chain_ctl.lower_cmd = rmth_pkg::CMD_PUSH;
				end
			end
			rmth_pkg::ST_DONE: begin
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rmth_pkg::ST_IDLE;
			lower_size_q <= '0;
			upper_size_q <= '0;
			median_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// Empty both halves on restart
			if (accept && restart) begin
				lower_size_q <= '0;
				upper_size_q <= '0;
				median_q     <= '0;
			end
			// Track occupancy as words cross and enter
			if (state_q == rmth_pkg::ST_MOVE) begin
				if (to_upper_q) begin
					upper_size_q <= upper_size_q - 1'b1;
					lower_size_q <= lower_size_q + 1'b1;
				end else begin
					lower_size_q <= lower_size_q - 1'b1;
					upper_size_q <= upper_size_q + 1'b1;
				end
			end
			if (state_q == rmth_pkg::ST_INSERT) begin
				if (to_upper_q) begin
					upper_size_q <= upper_size_q + 1'b1;
				end else begin
					lower_size_q <= lower_size_q + 1'b1;
				end
			end
			// Take the new median from the settled tops
			if (state_q == rmth_pkg::ST_MEDIAN) begin
				unique case (med_sel_q)
					rmth_pkg::MED_LOWER: median_q <= lower_top;
					rmth_pkg::MED_UPPER: median_q <= upper_top;
					rmth_pkg::MED_MEAN:  median_q <= mean_w;
					default:             median_q <= median_q;
				endcase
			end
			// Result register: set on load, drop once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample[S-1:0];
		end
		if (state_q == rmth_pkg::ST_DECIDE) begin
			flag_q     <= full;
			to_upper_q <= to_upper_d;
			move_q     <= move_d;
			med_sel_q  <= med_sel_d;
		end
		if (load_out) begin
			median_out_q <= rmth_pkg::WORD_W'(median_q);
			count_q      <= total_wide[rmth_pkg::COUNT_W-1:0];
			flag_out_q   <= flag_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign median_out    = median_out_q;
	assign count_held    = count_q;
	assign overflow_flag = flag_out_q;

	// Halves stay balanced between items
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmth_pkg::ST_IDLE |->
			(lower_size_q == upper_size_q) ||
			(lower_size_q == upper_size_q + 1'b1) ||
			(upper_size_q == lower_size_q + 1'b1))
		else $error("halves out of balance");

	// Never hold more than capacity
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		total <= CNT_W'(MAX_ITEMS))
		else $error("occupancy above capacity");

	// Chain contents agree with the counts
	a_lower_top: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmth_pkg::ST_IDLE |-> lower_top_valid == (lower_size_q != '0))
		else $error("lower chain top disagrees with count");

	a_upper_top: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmth_pkg::ST_IDLE |-> upper_top_valid == (upper_size_q != '0))
		else $error("upper chain top disagrees with count");

	// A move only pops a chain that holds a word
	a_move_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmth_pkg::ST_MOVE && move_q |->
			(to_upper_q ? upper_top_valid : lower_top_valid))
		else $error("move from an empty chain");

endmodule

// ----- hw/rtl/running_median_two_heaps_core.sv -----
// ----------------------------------------------------------------------------
// running_median_two_heaps_core: running median of a signed sample stream
//
// Input channel: in_valid/in_stall with sample and restart. Each accepted
// word adds one sample; restart empties both halves and zeroes the median
// before the sample is taken. Only the low SAMPLE_BITS bits of sample count.
// Output channel: out_valid/out_stall with median_out, count_held and
// overflow_flag; exactly one result word per input word, in order.
// The lower half sits in a max-ordered chain, the upper half in a
// min-ordered chain; each chain push or pop acts in all cells at once.
// After an accept the sequencer steps through decide, an optional move of a
// top to the other half, insert, median and done; a dropped sample goes from
// decide straight to done. It takes no new word until it is back in idle,
// so the controller's step sequence sets the rate.
// The result register lets the next word enter while a result waits; a
// stalled receiver holds the sequencer only when a new result is ready.
// Reset empties both chains and zeroes the median; no clearing pass.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core #(
	parameter int unsigned MAX_ITEMS   = rmth_pkg::MAX_ITEMS_DEF,
	parameter int unsigned SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [rmth_pkg::WORD_W-1:0]  sample,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [rmth_pkg::WORD_W-1:0]  median_out,
	output logic        [rmth_pkg::COUNT_W-1:0] count_held,
	output logic                                overflow_flag
);

	localparam int unsigned DEPTH = MAX_ITEMS / 2 + 1;

	rmth_pkg::chain_ctl_t        chain_ctl;
	logic signed [SAMPLE_BITS-1:0] lower_top, upper_top;
	logic                          lower_top_valid, upper_top_valid;
	logic signed [SAMPLE_BITS-1:0] lower_ins, upper_ins;

	// Sequencer and result register
	rmth_ctrl #(
		.MAX_ITEMS   (MAX_ITEMS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.DEPTH       (DEPTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.median_out      (median_out),
		.count_held      (count_held),
		.overflow_flag   (overflow_flag),
		.lower_top       (lower_top),
		.lower_top_valid (lower_top_valid),
		.upper_top       (upper_top),
		.upper_top_valid (upper_top_valid),
		.chain_ctl       (chain_ctl),
		.lower_ins       (lower_ins),
		.upper_ins       (upper_ins)
	);

	// Lower half, largest on top
	rmth_chain #(
		.W      (SAMPLE_BITS),
		.DEPTH  (DEPTH),
		.IS_MAX (1'b1)
	) u_lower (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (chain_ctl.lower_cmd),
		.ins_val   (lower_ins),
		.top_val   (lower_top),
		.top_valid (lower_top_valid)
	);

	// Upper half, smallest on top
	rmth_chain #(
		.W      (SAMPLE_BITS),
		.DEPTH  (DEPTH),
		.IS_MAX (1'b0)
	) u_upper (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (chain_ctl.upper_cmd),
		.ins_val   (upper_ins),
		.top_val   (upper_top),
		.top_valid (upper_top_valid)
	);

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for running_median_two_heaps_core
// Drives signed samples with restarts through the input channel and checks
// every result word against an in-bench two-heap median tracker. Covers the
// 33-bit mean of the two tops, ties with the current median, restarts,
// dropped samples at full capacity and a restart at full capacity. The
// sender idles in random bursts; the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WORD_W        = rmth_pkg::WORD_W;
	localparam int unsigned COUNT_W       = rmth_pkg::COUNT_W;
	localparam int unsigned CAPACITY      = rmth_pkg::MAX_ITEMS_DEF;
	localparam int unsigned SAMPLE_W      = rmth_pkg::SAMPLE_BITS_DEF;
	localparam int unsigned HALF_DEPTH    = CAPACITY / 2 + 1;
	localparam int unsigned MAX_PRINT     = 40;
	localparam int unsigned DRAIN_LIMIT   = 20000;
	localparam int unsigned SETTLE_CYCLES = 16;

	typedef struct {
		logic signed [WORD_W-1:0]  median;
		logic        [COUNT_W-1:0] held;
		logic                      dropped;
	} median_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [WORD_W-1:0]   sample;
	logic                       restart;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [WORD_W-1:0]   median_out;
	logic        [COUNT_W-1:0]  count_held;
	logic                       overflow_flag;

	// Tracker state: lower half max-ordered, upper half min-ordered
	logic signed [WORD_W-1:0]   lo_heap [HALF_DEPTH];
	logic signed [WORD_W-1:0]   hi_heap [HALF_DEPTH];
	int unsigned                lo_fill = 0;
	int unsigned                hi_fill = 0;
	logic signed [WORD_W-1:0]   run_median = '0;

	median_result_t             median_results_due[$];
	int unsigned                burst_left = 0;
	int unsigned                error_count = 0;
	int unsigned                sent_count = 0;
	int unsigned                restarts_sent = 0;
	int unsigned                results_seen = 0;
	int unsigned                drops_seen = 0;

	always #1 clk = ~clk;

	running_median_two_heaps_core #(
		.MAX_ITEMS   (CAPACITY),
		.SAMPLE_BITS (SAMPLE_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.median_out    (median_out),
		.count_held    (count_held),
		.overflow_flag (overflow_flag)
	);

	// ------------------------------------------------------------------
	// Median tracker
	// ------------------------------------------------------------------
	function automatic bit nearer_top(input bit is_lower, input logic signed [WORD_W-1:0] a,
	                                  input logic signed [WORD_W-1:0] b);
		return is_lower ? (a > b) : (a < b);
	endfunction

	function automatic logic signed [WORD_W-1:0] heap_at(input bit is_lower,
	                                                     input int unsigned idx);
		return is_lower ? lo_heap[idx] : hi_heap[idx];
	endfunction

	function automatic void heap_put(input bit is_lower, input int unsigned idx,
	                                 input logic signed [WORD_W-1:0] v);
		if (is_lower) begin
			lo_heap[idx] = v;
		end else begin
			hi_heap[idx] = v;
		end
	endfunction

	// Append at the bottom and sift toward the top
	task automatic heap_push(input bit is_lower, input logic signed [WORD_W-1:0] v);
		int unsigned              i;
		int unsigned              p;
		logic signed [WORD_W-1:0] t;
		i = is_lower ? lo_fill : hi_fill;
		if (i >= HALF_DEPTH) return;
		heap_put(is_lower, i, v);
		if (is_lower) begin
			lo_fill = i + 1;
		end else begin
			hi_fill = i + 1;
		end
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!nearer_top(is_lower, heap_at(is_lower, i), heap_at(is_lower, p))) break;
			t = heap_at(is_lower, i);
			heap_put(is_lower, i, heap_at(is_lower, p));
			heap_put(is_lower, p, t);
			i = p;
		end
	endtask

	// Take the top, move the last entry up and sift it down
	task automatic heap_pop(input bit is_lower, output logic signed [WORD_W-1:0] top);
		int unsigned              n;
		int unsigned              i;
		int unsigned              l;
		int unsigned              r;
		int unsigned              best;
		logic signed [WORD_W-1:0] t;
		n = is_lower ? lo_fill : hi_fill;
		top = '0;
		if (n == 0) return;
		top = heap_at(is_lower, 0);
		n--;
		if (is_lower) begin
			lo_fill = n;
		end else begin
			hi_fill = n;
		end
		heap_put(is_lower, 0, heap_at(is_lower, n));
		i = 0;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			best = i;
			if (l < n && nearer_top(is_lower, heap_at(is_lower, l), heap_at(is_lower, best)))
				best = l;
			if (r < n && nearer_top(is_lower, heap_at(is_lower, r), heap_at(is_lower, best)))
				best = r;
			if (best == i) break;
			t = heap_at(is_lower, i);
			heap_put(is_lower, i, heap_at(is_lower, best));
			heap_put(is_lower, best, t);
			i = best;
		end
	endtask

	// Sum at full width, halve toward zero
	function automatic logic signed [WORD_W-1:0] mean_of_tops();
		longint sum;
		sum = longint'(lo_heap[0]) + longint'(hi_heap[0]);
		return WORD_W'(sum / 2);
	endfunction

	task automatic predict_median(input logic signed [WORD_W-1:0] raw, input logic rs,
	                              output median_result_t res);
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] moved;
		x = (raw <<< (WORD_W - SAMPLE_W)) >>> (WORD_W - SAMPLE_W);
		res.dropped = 1'b0;
		if (rs) begin
			lo_fill = 0;
			hi_fill = 0;
			run_median = '0;
		end
		if (lo_fill + hi_fill >= CAPACITY) begin
			res.dropped = 1'b1;
		end else if (lo_fill == hi_fill) begin
			if (x > run_median) begin
				heap_push(1'b0, x);
				run_median = hi_heap[0];
			end else begin
				heap_push(1'b1, x);
				run_median = lo_heap[0];
			end
		end else if (lo_fill > hi_fill) begin
			if (x > run_median) begin
				heap_push(1'b0, x);
			end else begin
				heap_pop(1'b1, moved);
				heap_push(1'b0, moved);
				heap_push(1'b1, x);
			end
			run_median = mean_of_tops();
		end else begin
			if (x > run_median) begin
				heap_pop(1'b0, moved);
				heap_push(1'b1, moved);
				heap_push(1'b0, x);
			end else begin
				heap_push(1'b1, x);
			end
			run_median = mean_of_tops();
		end
		res.median = run_median;
		res.held   = COUNT_W'(lo_fill + hi_fill);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Mix full-range words, a narrow band, extremes and values near the median
	function automatic logic signed [WORD_W-1:0] pick_sample();
		logic signed [WORD_W-1:0] corner [7];
		corner = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1,
		           32'sh7ffffffe, 32'sh80000001};
		unique case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return int'($urandom_range(0, 16)) - 8;
			7:          return corner[$urandom_range(0, 6)];
			default:    return run_median + (int'($urandom_range(0, 4)) - 2);
		endcase
	endfunction

	// Send one word; idle between bursts, hold the payload while stalled
	task automatic send_sample(input logic signed [WORD_W-1:0] s, input logic rs);
		int unsigned    gap;
		median_result_t res;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		sample   <= s;
		restart  <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_median(s, rs, res);
		median_results_due.push_back(res);
		sent_count++;
		if (rs) restarts_sent++;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= MAX_PRINT)
			$display("[%0t] %s: got %0d, expected %0d (result #%0d)",
			         $time, what, got, want, results_seen);
	endtask

	// ------------------------------------------------------------------
	// Receiver stall pattern: free, light, heavy or alternating stretches
	// ------------------------------------------------------------------
	initial begin : rx_stall_gen
		int unsigned mode;
		int unsigned left;
		mode = 0;
		left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(8, 60);
			end
			left--;
			unique case (mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				2:       out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		median_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (median_results_due.size() == 0) begin
				report_mismatch("unexpected result word", median_out, 0);
			end else begin
				want = median_results_due.pop_front();
				if (median_out !== want.median)
					report_mismatch("median_out", median_out, want.median);
				if (count_held !== want.held)
					report_mismatch("count_held", count_held, want.held);
				if (overflow_flag !== want.dropped)
					report_mismatch("overflow_flag", overflow_flag, want.dropped);
			end
			results_seen++;
			if (overflow_flag === 1'b1) drops_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Extremes, full-width sums, truncation toward zero, ties and restarts
	task automatic test_directed();
		logic signed [WORD_W-1:0] vals [16];
		logic                     rst  [16];
		vals = '{32'sh0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
		         -32'sd3, 32'sd0, 32'sd5, -32'sd10, 32'sd100, 32'sd100, -32'sd7,
		         32'sd1, 32'sd0, 32'sh55555555, 32'shaaaaaaaa};
		rst  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		         1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
		foreach (vals[k]) send_sample(vals[k], rst[k]);
	endtask

	// Fill to capacity, drop the excess, then restart while full
	task automatic test_capacity_overflow();
		send_sample(pick_sample(), 1'b1);
		for (int unsigned n = 1; n < CAPACITY; n++) send_sample(pick_sample(), 1'b0);
		repeat (12) send_sample(pick_sample(), 1'b0);
		send_sample(pick_sample(), 1'b1);
		repeat (8) send_sample(pick_sample(), 1'b0);
	endtask

	// Random words with occasional restarts
	task automatic test_random_restarts();
		repeat (150) send_sample(pick_sample(), $urandom_range(0, 29) == 0);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		int unsigned waited;
		arst_n   = 1'b0;
		in_valid <= 1'b0;
		sample   <= '0;
		restart  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity_overflow();
		test_random_restarts();
		in_valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		waited = 0;
		while (median_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (median_results_due.size() != 0)
			report_mismatch("results never delivered", median_results_due.size(), 0);

		$display("Run: %0d words sent (%0d with restart), %0d results checked.",
		         sent_count, restarts_sent, results_seen);
		$display("Dropped at full capacity: %0d; mismatches: %0d.", drops_seen, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin : watchdog
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/rmth_pkg.sv
hw/rtl/rmth_cell.sv
hw/rtl/rmth_chain.sv
hw/rtl/rmth_ctrl.sv
hw/rtl/running_median_two_heaps_core.sv
dv/tb.sv
